// ===== hw/rtl/pla_pkg.sv =====
// ----------------------------------------------------------------------------
// pla_pkg
// shared constants, codes and control structs of the partial argsort block
// ----------------------------------------------------------------------------
package pla_pkg;

    localparam int POINTS        = 64;
    localparam int IDX_W         = 6;
    localparam int CNT_W         = 7;
    localparam int MAX_KEY_WORDS = 4;
    localparam int STORE_WORDS   = POINTS * MAX_KEY_WORDS;
    localparam int KADDR_W       = 8;
    localparam int WC_W          = 9;

    localparam logic [63:0] NA_KEY = 64'h8000_0000_0000_0000;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [1:0] CFG_NA_MODE   = 2'd0;
    localparam logic [1:0] CFG_KEY_WORDS = 2'd1;
    localparam logic [1:0] CFG_RANK_FROM = 2'd2;
    localparam logic [1:0] CFG_RANK_TO   = 2'd3;

    localparam logic [1:0] NA_NONE  = 2'd0;
    localparam logic [1:0] NA_LAST  = 2'd1;
    localparam logic [1:0] NA_FIRST = 2'd2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NA_MULTI = 2'd1,
        ST_BAD_SET  = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef struct packed {
        logic              start;
        logic [WC_W-1:0]   wc;
        logic              err0;
        logic [2:0]        kw;
        logic [1:0]        mode;
        logic signed [7:0] win_lo;
        logic signed [7:0] win_hi;
    } t_sort_cmd;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [1:0]       err;
        logic [CNT_W-1:0] len;
    } t_sort_rsp;

endpackage

// ===== hw/rtl/pla_in_if.sv =====
// ----------------------------------------------------------------------------
// pla_in_if
// input channel: command, key word and closing flag with valid/ready
// ----------------------------------------------------------------------------
interface pla_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [63:0] key_word;
    logic               last_word;

    modport source (output valid, output command, output key_word, output last_word,
                    input ready);
    modport sink   (input valid, input command, input key_word, input last_word,
                    output ready);
endinterface

// ===== hw/rtl/pla_out_if.sv =====
// ----------------------------------------------------------------------------
// pla_out_if
// result channel: sorted index, final position flag and status
// ----------------------------------------------------------------------------
interface pla_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] sorted_index;
    logic       last_index;
    logic [1:0] status;

    modport source (output valid, output sorted_index, output last_index, output status,
                    input ready);
    modport sink   (input valid, input sorted_index, input last_index, input status,
                    output ready);
endinterface

// ===== hw/rtl/partial_lexicographic_argsort.sv =====
// ----------------------------------------------------------------------------
// partial_lexicographic_argsort
// loads multiword signed keys and returns an argsort exact within a rank window
// ----------------------------------------------------------------------------
// i_in carries load and read commands; a load transfer writes one key word,
// most significant word of each record first, and last_word closes the set.
// closing a set starts the sort: a word-count check, a permutation setup
// over every record, then the quicksort, where each element compare reads
// key words one at a time on the key memory read port until one differs.
// i_in.ready stays low while sorting. a read transfer gives one transfer
// on o_out: an ok index passes r_pend and the permutation read register
// before the output register; a status-only result is registered directly.
// loads are taken back to back; one read is in flight at a time and a new
// transfer is taken once the previous result has left the output register.
// configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data and is
// sampled when the closing word arrives.
// after reset the block is loading an empty set and no results are ready; the
// key and permutation memories are not cleared.
// a stalled o_out holds its result and blocks i_in until it is taken.
// ----------------------------------------------------------------------------
module partial_lexicographic_argsort (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [6:0]  i_cfg_data,
    pla_in_if.sink      i_in,
    pla_out_if.source   o_out
);
    import pla_pkg::*;

    logic signed [63:0]  key_mem [STORE_WORDS];
    logic signed [63:0]  r_key_rd;
    logic [KADDR_W-1:0]  key_raddr;

    logic [1:0]          r_na_mode;
    logic [2:0]          r_key_words;
    logic [6:0]          r_rank_from, r_rank_to;

    logic                r_loading, r_ready, r_pend, r_start;
    logic [WC_W-1:0]     r_wc;
    logic [1:0]          r_err;
    logic [CNT_W-1:0]    r_rp, r_len;
    t_sort_cmd           r_cmd;
    t_sort_rsp           rsp;
    logic [IDX_W-1:0]    prd_data;

    logic                r_out_valid, r_out_last;
    logic [IDX_W-1:0]    r_out_idx;
    t_status             r_out_status;

    logic                in_acc, ld_acc, rd_acc, key_we;
    logic [WC_W-1:0]     wc_cur;
    logic                e0_cur;

    assign i_in.ready = !r_start && !rsp.busy && !r_out_valid && !r_pend;
    assign in_acc = i_in.valid && i_in.ready;
    assign ld_acc = in_acc && (i_in.command == CMD_LOAD);
    assign rd_acc = in_acc && (i_in.command == CMD_READ);
    assign wc_cur = r_loading ? r_wc : '0;
    assign e0_cur = r_loading ? r_err[0] : 1'b0;
    assign key_we = ld_acc && (wc_cur < WC_W'(STORE_WORDS));

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[wc_cur[KADDR_W-1:0]] <= i_in.key_word;
        end
        r_key_rd <= key_mem[key_raddr];
    end

    pla_sorter u_sorter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (r_cmd),
        .o_rsp       (rsp),
        .o_key_raddr (key_raddr),
        .i_key_rdata (r_key_rd),
        .i_prd_addr  (r_rp[IDX_W-1:0]),
        .o_prd_data  (prd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_na_mode   <= NA_NONE;
            r_key_words <= 3'd1;
            r_rank_from <= 7'd1;
            r_rank_to   <= 7'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NA_MODE:   r_na_mode   <= i_cfg_data[1:0];
                CFG_KEY_WORDS: r_key_words <= i_cfg_data[2:0];
                CFG_RANK_FROM: r_rank_from <= i_cfg_data;
                CFG_RANK_TO:   r_rank_to   <= i_cfg_data;
                default:       r_rank_to   <= r_rank_to;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loading   <= 1'b1;
            r_ready     <= 1'b0;
            r_pend      <= 1'b0;
            r_start     <= 1'b0;
            r_wc        <= '0;
            r_err       <= 2'd0;
            r_rp        <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
            r_cmd       <= '0;
        end else begin
            r_start     <= 1'b0;
            r_cmd.start <= 1'b0;
            r_pend      <= 1'b0;
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            // load transfer
            if (ld_acc) begin
                r_loading <= 1'b1;
                r_ready   <= 1'b0;
                r_wc      <= key_we ? wc_cur + 9'd1 : wc_cur;
                r_err     <= {1'b0, e0_cur || !key_we};
                if (i_in.last_word) begin
                    r_loading     <= 1'b0;
                    r_start       <= 1'b1;
                    r_cmd.start   <= 1'b1;
                    r_cmd.wc      <= key_we ? wc_cur + 9'd1 : wc_cur;
                    r_cmd.err0    <= e0_cur || !key_we;
                    r_cmd.kw      <= r_key_words;
                    r_cmd.mode    <= r_na_mode;
                    r_cmd.win_lo  <= $signed({1'b0, r_rank_from} - 8'd1);
                    r_cmd.win_hi  <= $signed({1'b0, r_rank_to} - 8'd1);
                end
            end
            if (rsp.done) begin
                r_ready <= 1'b1;
                r_err   <= rsp.err;
                r_len   <= rsp.len;
                r_rp    <= '0;
            end
            // read transfer
            if (rd_acc) begin
                r_out_idx    <= '0;
                r_out_last   <= 1'b0;
                r_out_status <= ST_EMPTY;
                if (!r_ready) begin
                    r_out_valid <= 1'b1;
                end else if (r_err != 2'd0) begin
                    r_out_valid  <= 1'b1;
                    r_out_last   <= 1'b1;
                    r_out_status <= r_err[0] ? ST_BAD_SET : ST_NA_MULTI;
                    r_ready      <= 1'b0;
                end else if (r_rp < r_len) begin
                    r_pend <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                    r_ready     <= 1'b0;
                end
            end
            if (r_pend) begin
                r_out_valid  <= 1'b1;
                r_out_idx    <= prd_data;
                r_out_last   <= (r_rp + 7'd1 == r_len);
                r_out_status <= ST_OK;
                r_rp         <= r_rp + 7'd1;
                if (r_rp + 7'd1 >= r_len) begin
                    r_ready <= 1'b0;
                end
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.sorted_index = r_out_idx;
    assign o_out.last_index   = r_out_last;
    assign o_out.status       = r_out_status;

endmodule

// ===== hw/rtl/pla_sorter.sv =====
// ----------------------------------------------------------------------------
// pla_sorter
// set check, permutation setup and windowed quicksort over the permutation
// memory, with the range stack in a second memory
// ----------------------------------------------------------------------------
module pla_sorter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pla_pkg::t_sort_cmd          i_cmd,
    output pla_pkg::t_sort_rsp          o_rsp,
    output logic [pla_pkg::KADDR_W-1:0] o_key_raddr,
    input  logic signed [63:0]          i_key_rdata,
    input  logic [pla_pkg::IDX_W-1:0]   i_prd_addr,
    output logic [pla_pkg::IDX_W-1:0]   o_prd_data
);
    import pla_pkg::*;

    typedef enum logic [22:0] {
        S_IDLE    = 23'h000001,
        S_DIV     = 23'h000002,
        S_INIT_RD = 23'h000004,
        S_INIT_WR = 23'h000008,
        S_POP     = 23'h000010,
        S_POPW    = 23'h000020,
        S_SRD     = 23'h000040,
        S_SWA     = 23'h000080,
        S_SWB     = 23'h000100,
        S_PKR     = 23'h000200,
        S_PKW     = 23'h000400,
        S_LSTEP   = 23'h000800,
        S_LWT     = 23'h001000,
        S_CMPR    = 23'h002000,
        S_CMPW    = 23'h004000,
        S_RSTEP   = 23'h008000,
        S_RWT     = 23'h010000,
        S_SWCHK   = 23'h020000,
        S_SWD     = 23'h040000,
        S_FINW    = 23'h080000,
        S_FIN2    = 23'h100000,
        S_PSH1    = 23'h200000,
        S_PSH2    = 23'h400000
    } t_state;

    logic [IDX_W-1:0]     perm_mem [POINTS];
    logic [2*IDX_W-1:0]   stack_mem [POINTS];
    logic [IDX_W-1:0]     r_prd;
    logic [2*IDX_W-1:0]   r_srd;

    t_state               r_state, n_state;
    logic [2:0]           r_kw, n_kw;
    logic [1:0]           r_mode, n_mode;
    logic signed [7:0]    r_wlo, n_wlo, r_whi, n_whi;
    logic [WC_W-1:0]      r_wc, n_wc, r_acc, n_acc, r_n, n_n;
    logic                 r_e0, n_e0;
    logic [CNT_W-1:0]     r_i, n_i, r_len, n_len, r_sp, n_sp, r_l, n_l, r_r, n_r;
    logic signed [7:0]    r_lo, n_lo, r_hi, n_hi;
    logic [IDX_W-1:0]     r_s, n_s, r_e, n_e, r_pp, n_pp, r_piv, n_piv;
    logic [IDX_W-1:0]     r_vl, n_vl, r_vr, n_vr, r_ve, n_ve;
    logic [2:0]           r_d, n_d;
    logic                 r_ret, n_ret;
    logic signed [63:0]   r_pk [MAX_KEY_WORDS];
    logic                 pk_we;

    logic                 pw_en;
    logic [IDX_W-1:0]     pw_addr, pw_data, pr_addr;
    logic                 sw_en;
    logic [IDX_W-1:0]     sw_addr, sr_addr;
    logic [2*IDX_W-1:0]   sw_data;

    logic [9:0]           acc_nx;
    logic                 kw_bad, e0_fin, e1_fin;
    logic [IDX_W-1:0]     mid, mid_pop;
    logic [CNT_W-1:0]     l_nx, r_nx;
    logic signed [7:0]    first, last, pp_sg, s_sg, e_sg;
    logic                 is_na, k_ne, k_lt, push1, push2;
    logic [8:0]           ve_prod, piv_prod;

    always_ff @(posedge i_clk) begin
        if (pw_en) begin
            perm_mem[pw_addr] <= pw_data;
        end
        r_prd <= perm_mem[pr_addr];
        if (sw_en) begin
            stack_mem[sw_addr] <= sw_data;
        end
        r_srd <= stack_mem[sr_addr];
        if (pk_we) begin
            r_pk[r_d[1:0]] <= i_key_rdata;
        end
    end

    always_comb begin
        acc_nx   = {1'b0, r_acc} + {7'd0, r_kw};
        kw_bad   = (r_kw == 3'd0) || (r_kw > 3'(MAX_KEY_WORDS));
        e0_fin   = r_e0 || kw_bad || (r_acc != r_wc) || (r_n > WC_W'(POINTS)) ||
                   (r_n == '0);
        e1_fin   = (r_mode != NA_NONE) && (r_kw != 3'd1);
        mid      = 6'(({1'b0, r_s} + {1'b0, r_e}) >> 1);
        mid_pop  = 6'(({1'b0, r_srd[2*IDX_W-1:IDX_W]} + {1'b0, r_srd[IDX_W-1:0]}) >> 1);
        l_nx     = r_l + 7'd1;
        r_nx     = r_r - 7'd1;
        first    = (r_mode == NA_FIRST) ? r_hi : 8'sd0;
        last     = (r_mode == NA_FIRST) ? $signed({1'b0, r_len} - 8'd1) : r_lo;
        pp_sg    = $signed({2'b00, r_pp});
        s_sg     = $signed({2'b00, r_s});
        e_sg     = $signed({2'b00, r_e});
        is_na    = (r_mode != NA_NONE) && (i_key_rdata == NA_KEY);
        k_ne     = i_key_rdata != r_pk[r_d[1:0]];
        k_lt     = i_key_rdata < r_pk[r_d[1:0]];
        ve_prod  = ({3'd0, r_ve} * {6'd0, r_kw}) + {6'd0, r_d};
        piv_prod = ({3'd0, r_piv} * {6'd0, r_kw}) + {6'd0, r_d};
        push1    = (pp_sg < r_whi) && (e_sg >= r_wlo) &&
                   ({1'b0, r_pp} + 7'd1 < {1'b0, r_e}) && (r_sp < 7'(POINTS));
        push2    = (s_sg <= r_whi) && (pp_sg > r_wlo) &&
                   ({1'b0, r_s} + 7'd1 < {1'b0, r_pp}) && (r_sp < 7'(POINTS));

        n_state = r_state; n_kw = r_kw; n_mode = r_mode; n_wlo = r_wlo; n_whi = r_whi;
        n_wc = r_wc; n_acc = r_acc; n_n = r_n; n_e0 = r_e0; n_i = r_i; n_len = r_len;
        n_sp = r_sp; n_l = r_l; n_r = r_r; n_lo = r_lo; n_hi = r_hi; n_s = r_s;
        n_e = r_e; n_pp = r_pp; n_piv = r_piv; n_vl = r_vl; n_vr = r_vr; n_ve = r_ve;
        n_d = r_d; n_ret = r_ret;
        pk_we = 1'b0;
        pw_en = 1'b0; pw_addr = '0; pw_data = '0; pr_addr = i_prd_addr;
        sw_en = 1'b0; sw_addr = '0; sw_data = '0; sr_addr = '0;
        o_key_raddr = '0;
        o_rsp.busy = (r_state != S_IDLE);
        o_rsp.done = 1'b0;
        o_rsp.err  = 2'd0;
        o_rsp.len  = r_len;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_wc = i_cmd.wc; n_e0 = i_cmd.err0; n_kw = i_cmd.kw;
                    n_mode = (i_cmd.mode == 2'd3) ? NA_NONE : i_cmd.mode;
                    n_wlo = i_cmd.win_lo; n_whi = i_cmd.win_hi;
                    n_acc = '0; n_n = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (!kw_bad && acc_nx <= {1'b0, r_wc}) begin
                    n_acc = acc_nx[WC_W-1:0];
                    n_n = r_n + 9'd1;
                end else if (e0_fin || e1_fin) begin
                    o_rsp.done = 1'b1;
                    o_rsp.err  = {e1_fin, e0_fin};
                    o_rsp.len  = '0;
                    n_len = '0;
                    n_state = S_IDLE;
                end else begin
                    n_len = r_n[CNT_W-1:0];
                    n_i = '0; n_lo = -8'sd1; n_hi = $signed({1'b0, r_n[CNT_W-1:0]});
                    n_state = S_INIT_RD;
                end
            end
            S_INIT_RD: begin
                if (r_i == r_len) begin
                    n_sp = '0;
                    if (first < last) begin
                        sw_en = 1'b1;
                        sw_data = {first[IDX_W-1:0], last[IDX_W-1:0]};
                        n_sp = 7'd1;
                    end
                    n_state = S_POP;
                end else begin
                    o_key_raddr = {2'b00, r_i[IDX_W-1:0]};
                    n_state = S_INIT_WR;
                end
            end
            S_INIT_WR: begin
                pw_en = 1'b1;
                pw_data = r_i[IDX_W-1:0];
                if ((r_mode == NA_FIRST) == is_na) begin
                    n_lo = r_lo + 8'sd1;
                    pw_addr = n_lo[IDX_W-1:0];
                end else begin
                    n_hi = r_hi - 8'sd1;
                    pw_addr = n_hi[IDX_W-1:0];
                end
                n_i = r_i + 7'd1;
                n_state = S_INIT_RD;
            end
            S_POP: begin
                if (r_sp == '0) begin
                    o_rsp.done = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_sp = r_sp - 7'd1;
                    sr_addr = n_sp[IDX_W-1:0];
                    n_state = S_POPW;
                end
            end
            S_POPW: begin
                n_s = r_srd[2*IDX_W-1:IDX_W];
                n_e = r_srd[IDX_W-1:0];
                pr_addr = mid_pop;
                n_state = S_SRD;
            end
            S_SRD: begin
                n_piv = r_prd;
                pr_addr = r_s;
                n_state = S_SWA;
            end
            S_SWA: begin
                pw_en = 1'b1; pw_addr = mid; pw_data = r_prd;
                n_state = S_SWB;
            end
            S_SWB: begin
                pw_en = 1'b1; pw_addr = r_s; pw_data = r_piv;
                n_d = '0;
                n_state = S_PKR;
            end
            S_PKR: begin
                o_key_raddr = piv_prod[KADDR_W-1:0];
                n_state = S_PKW;
            end
            S_PKW: begin
                pk_we = 1'b1;
                if (r_d + 3'd1 == r_kw) begin
                    n_l = {1'b0, r_s}; n_r = {1'b0, r_e} + 7'd1; n_pp = r_s;
                    n_state = S_LSTEP;
                end else begin
                    n_d = r_d + 3'd1;
                    n_state = S_PKR;
                end
            end
            S_LSTEP: begin
                n_l = l_nx;
                if (l_nx < r_r) begin
                    pr_addr = l_nx[IDX_W-1:0];
                    n_state = S_LWT;
                end else begin
                    n_state = S_RSTEP;
                end
            end
            S_LWT: begin
                n_ve = r_prd; n_vl = r_prd; n_d = '0; n_ret = 1'b0;
                n_state = S_CMPR;
            end
            S_CMPR: begin
                o_key_raddr = ve_prod[KADDR_W-1:0];
                n_state = S_CMPW;
            end
            S_CMPW: begin
                if (k_ne || (r_d + 3'd1 == r_kw)) begin
                    if (!r_ret) begin
                        if (k_ne && k_lt) begin
                            n_pp = r_pp + 6'd1;
                            n_state = S_LSTEP;
                        end else begin
                            n_state = S_RSTEP;
                        end
                    end else begin
                        n_state = (k_ne && !k_lt) ? S_RSTEP : S_SWCHK;
                    end
                end else begin
                    n_d = r_d + 3'd1;
                    n_state = S_CMPR;
                end
            end
            S_RSTEP: begin
                n_r = r_nx;
                if (r_nx > r_l) begin
                    pr_addr = r_nx[IDX_W-1:0];
                    n_state = S_RWT;
                end else begin
                    n_state = S_SWCHK;
                end
            end
            S_RWT: begin
                n_ve = r_prd; n_vr = r_prd; n_d = '0; n_ret = 1'b1;
                n_state = S_CMPR;
            end
            S_SWCHK: begin
                if (r_l < r_r) begin
                    pw_en = 1'b1; pw_addr = r_l[IDX_W-1:0]; pw_data = r_vr;
                    n_state = S_SWD;
                end else begin
                    pr_addr = r_pp;
                    n_state = S_FINW;
                end
            end
            S_SWD: begin
                pw_en = 1'b1; pw_addr = r_r[IDX_W-1:0]; pw_data = r_vl;
                n_pp = r_pp + 6'd1;
                n_state = S_LSTEP;
            end
            S_FINW: begin
                pw_en = 1'b1; pw_addr = r_s; pw_data = r_prd;
                n_state = S_FIN2;
            end
            S_FIN2: begin
                pw_en = 1'b1; pw_addr = r_pp; pw_data = r_piv;
                n_state = S_PSH1;
            end
            S_PSH1: begin
                if (push1) begin
                    sw_en = 1'b1; sw_addr = r_sp[IDX_W-1:0];
                    sw_data = {r_pp + 6'd1, r_e};
                    n_sp = r_sp + 7'd1;
                end
                n_state = S_PSH2;
            end
            S_PSH2: begin
                if (push2) begin
                    sw_en = 1'b1; sw_addr = r_sp[IDX_W-1:0];
                    sw_data = {r_s, r_pp - 6'd1};
                    n_sp = r_sp + 7'd1;
                end
                n_state = S_POP;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sp    <= '0;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            r_len   <= n_len;
        end
        r_kw <= n_kw; r_mode <= n_mode; r_wlo <= n_wlo; r_whi <= n_whi;
        r_wc <= n_wc; r_acc <= n_acc; r_n <= n_n; r_e0 <= n_e0; r_i <= n_i;
        r_l <= n_l; r_r <= n_r; r_lo <= n_lo; r_hi <= n_hi; r_s <= n_s; r_e <= n_e;
        r_pp <= n_pp; r_piv <= n_piv; r_vl <= n_vl; r_vr <= n_vr; r_ve <= n_ve;
        r_d <= n_d; r_ret <= n_ret;
    end

    assign o_prd_data = r_prd;

endmodule
